[rtl/asr_pkg.sv]
`timescale 1ns / 1ps
package asr_pkg;

   localparam int DEF_BUFFER_DEPTH  = 131072;
   localparam int DEF_SAMPLE_BITS   = 24;
   localparam int DEF_FRACTION_BITS = 16;

   localparam logic [16:0] GAIN_ONE  = 17'd65536;
   localparam logic [16:0] GAIN_STOP = 17'd66;
   localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_SLICE = 3'd1;
   localparam logic [2:0] REG_DECAY = 3'd2;
   localparam logic [2:0] REG_SPEED = 3'd3;
   localparam logic [2:0] REG_MIX   = 3'd4;
   localparam logic [2:0] REG_SEED  = 3'd5;

   localparam logic [1:0] MODE_NORMAL   = 2'd0;
   localparam logic [1:0] MODE_REVERSE  = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;
   localparam logic [1:0] MODE_RANDOM   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIG, ST_OFFS, ST_POS, ST_RD0, ST_RD1, ST_INTP, ST_GAIN, ST_MIX, ST_OUT
   } state_type;

   typedef struct packed {
      logic trig;
      logic offs;
      logic pos;
      logic rd0;
      logic rd1;
      logic intp;
      logic gain;
      logic mix;
   } step_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [17:0] slice;
      logic [16:0] decay;
      logic [17:0] speed;
      logic [16:0] mix;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:  MODE_NORMAL,
      slice: 18'd4800,
      decay: 17'd52429,
      speed: 18'd65536,
      mix:   17'd32768
   };
   localparam logic [31:0] SEED_RESET = 32'd1;

endpackage

[rtl/audio_stutter_repeater.sv]
`timescale 1ns / 1ps
// channel  direction  fields
// req      in         tdata: in_left, in_right, note_on, note_off
// rsp      out        tdata: out_left, out_right, stutter_active, repeat_count
// csr      in         index 0..5: mode, slice, decay, speed, mix, seed
//
// after a request is accepted, a sequencer walks position setup, two reads of each
// channel's ring memory, interpolation, gain and mix, then presents the result; a new
// request is taken only once the sequencer has returned to idle.
// left and right lanes run side by side; results merge into one output register.
// reset is synchronous; ring entries not yet written read as zero via a fill mark.
// the next request is accepted while a result waits; a stalled rsp holds the last step.
module audio_stutter_repeater #(
   parameter int BUFFER_DEPTH  = asr_pkg::DEF_BUFFER_DEPTH,
   parameter int SAMPLE_BITS   = asr_pkg::DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = asr_pkg::DEF_FRACTION_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // in_left, in_right, note_on, note_off, zero pad
   input  logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]          req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // out_left, out_right, stutter_active, repeat_count, zero pad
   output logic [((2*SAMPLE_BITS+17+7)/8)*8-1:0]         rsp_tdata,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [2:0]                                    csr_index,
   input  logic [31:0]                                   csr_data
);
   import asr_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(BUFFER_DEPTH);
   localparam int FB  = FRACTION_BITS;
   localparam int RSW = ((2*SB+17+7)/8)*8;

   state_type state_ff, state_in;
   step_type  step;
   cfg_type   cfg_ff;

   logic signed [SB-1:0] dry_l_ff, dry_r_ff;
   logic                 on_ff, off_ff;
   logic                 rsp_valid_ff;
   logic [RSW-1:0]       rsp_data_ff;

   logic                 req_fire, out_free, seed_load;
   logic [AW-1:0]        addr0, addr1, wr_addr;
   logic [FB-1:0]        frac;
   logic                 valid0, valid1, replay, wr_en;
   logic [16:0]          gain, mix_c;
   logic [15:0]          repeats;
   logic signed [SB-1:0] mixed_l, mixed_r;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign seed_load = csr_valid && (csr_index == REG_SEED);
   assign mix_c     = (cfg_ff.mix > GAIN_ONE) ? GAIN_ONE : cfg_ff.mix;
   assign wr_en     = step.mix && !replay;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:  cfg_ff.mode  <= csr_data[1:0];
            REG_SLICE: cfg_ff.slice <= csr_data[17:0];
            REG_DECAY: cfg_ff.decay <= csr_data[16:0];
            REG_SPEED: cfg_ff.speed <= csr_data[17:0];
            REG_MIX:   cfg_ff.mix   <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            step.trig = 1'b1;
            state_in  = ST_OFFS;
         end
         ST_OFFS: begin
            step.offs = 1'b1;
            state_in  = ST_POS;
         end
         ST_POS: begin
            step.pos = 1'b1;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            step.rd0 = 1'b1;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            step.rd1 = 1'b1;
            state_in = ST_INTP;
         end
         ST_INTP: begin
            step.intp = 1'b1;
            state_in  = ST_GAIN;
         end
         ST_GAIN: begin
            step.gain = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            step.mix = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dry_l_ff <= req_tdata[SB-1:0];
         dry_r_ff <= req_tdata[2*SB-1:SB];
         on_ff    <= req_tdata[2*SB];
         off_ff   <= req_tdata[2*SB+1];
      end
   end

   asr_ctrl #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg_ff),
      .seed_load  (seed_load),
      .seed_value (csr_data),
      .note_on    (on_ff),
      .note_off   (off_ff),
      .addr0      (addr0),
      .addr1      (addr1),
      .wr_addr    (wr_addr),
      .frac       (frac),
      .valid0     (valid0),
      .valid1     (valid1),
      .replay     (replay),
      .gain       (gain),
      .repeats    (repeats)
   );

   asr_lane #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_l (
      .clock   (clock),
      .step    (step),
      .addr0   (addr0),
      .addr1   (addr1),
      .wr_addr (wr_addr),
      .wr_en   (wr_en),
      .valid0  (valid0),
      .valid1  (valid1),
      .frac    (frac),
      .replay  (replay),
      .gain    (gain),
      .mix     (mix_c),
      .dry     (dry_l_ff),
      .mixed   (mixed_l)
   );

   asr_lane #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_r (
      .clock   (clock),
      .step    (step),
      .addr0   (addr0),
      .addr1   (addr1),
      .wr_addr (wr_addr),
      .wr_en   (wr_en),
      .valid0  (valid0),
      .valid1  (valid1),
      .frac    (frac),
      .replay  (replay),
      .gain    (gain),
      .mix     (mix_c),
      .dry     (dry_r_ff),
      .mixed   (mixed_r)
   );

   // merge both lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= RSW'({repeats, replay, mixed_r, mixed_l});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_seq_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_TRIG) && !req_tready)
      else $error("request accepted while sequencer busy");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && out_free |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("finished request not presented on rsp");

   a_no_write_on_replay: assert property (@(posedge clock) disable iff (reset)
      step.mix && replay |-> !wr_en)
      else $error("ring written during replay");

endmodule

[rtl/asr_ctrl.sv]
`timescale 1ns / 1ps
module asr_ctrl #(
   parameter int BUFFER_DEPTH  = 131072,
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  asr_pkg::step_type                 step,
   input  asr_pkg::cfg_type                  cfg,
   input  logic                              seed_load,
   input  logic [31:0]                       seed_value,
   input  logic                              note_on,
   input  logic                              note_off,
   output logic [$clog2(BUFFER_DEPTH)-1:0]   addr0,
   output logic [$clog2(BUFFER_DEPTH)-1:0]   addr1,
   output logic [$clog2(BUFFER_DEPTH)-1:0]   wr_addr,
   output logic [FRACTION_BITS-1:0]          frac,
   output logic                              valid0,
   output logic                              valid1,
   output logic                              replay,
   output logic [16:0]                       gain,
   output logic [15:0]                       repeats
);
   import asr_pkg::*;

   localparam int AW  = $clog2(BUFFER_DEPTH);
   localparam int FB  = FRACTION_BITS;
   localparam int PW  = AW + FB;
   localparam int LW  = AW + 1;
   localparam int QW  = LW + FB;
   localparam int SHL = (FB >= 16) ? FB - 16 : 0;
   localparam int SHR = (FB >= 16) ? 0 : 16 - FB;
   localparam int OW  = LW + 16;
   localparam int CW  = OW + SHL;
   localparam int SW  = (CW > QW) ? CW : QW;
   localparam int VW  = 18 + SHL;

   logic [AW-1:0] wp_ff;
   logic          wrapped_ff;
   logic          active_ff;
   logic [LW-1:0] len_ff;
   logic [QW-1:0] pos_ff;
   logic [16:0]   gain_ff;
   logic          fwd_ff;
   logic [15:0]   rstart_ff;
   logic [31:0]   lfsr_ff;
   logic [15:0]   rep_ff;
   logic [OW-1:0] off_ff;
   logic          replay_ff;
   logic [AW-1:0] addr0_ff, addr1_ff;
   logic [FB-1:0] frac_ff;
   logic          v0_ff, v1_ff;

   logic [31:0]   lfsr_in;
   logic [LW-1:0] clip_len;
   logic [CW-1:0] off_c;
   logic [PW-1:0] wp_q, p_rand, p_fwd, p_rev, p_sel;
   logic [QW-1:0] len_q, speed_q, pos_sum;
   logic [AW-1:0] i0, i1;
   logic          fwd_now;
   logic [16:0]   decay_c;
   logic [33:0]   gain_prod;
   logic [16:0]   gain_next;

   always_comb begin
      lfsr_in  = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? LFSR_MASK : 32'd0);
      clip_len = (32'(cfg.slice) > 32'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : LW'(cfg.slice);
      off_c    = (CW'(off_ff) << SHL) >> SHR;
      wp_q     = {wp_ff, {FB{1'b0}}};
      len_q    = {len_ff, {FB{1'b0}}};
      p_rand   = PW'(SW'(off_c) + SW'(pos_ff));
      p_fwd    = PW'(QW'(wp_q) - len_q + pos_ff);
      p_rev    = wp_q - PW'(pos_ff);
      fwd_now  = (cfg.mode == MODE_NORMAL) || (cfg.mode == MODE_PINGPONG && fwd_ff);
      if (cfg.mode == MODE_RANDOM) begin
         p_sel = p_rand;
      end else if (fwd_now) begin
         p_sel = p_fwd;
      end else begin
         p_sel = p_rev;
      end
      i0        = p_sel[PW-1:FB];
      i1        = i0 + AW'(1);
      speed_q   = QW'((VW'(cfg.speed) << SHL) >> SHR);
      pos_sum   = pos_ff + speed_q;
      decay_c   = (cfg.decay > GAIN_ONE) ? GAIN_ONE : cfg.decay;
      gain_prod = 34'(gain_ff) * 34'(decay_c);
      gain_next = gain_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         active_ff  <= 1'b0;
         len_ff     <= '0;
         pos_ff     <= '0;
         gain_ff    <= GAIN_ONE;
         fwd_ff     <= 1'b1;
         rstart_ff  <= '0;
         lfsr_ff    <= SEED_RESET;
         rep_ff     <= '0;
         replay_ff  <= 1'b0;
      end else begin
         if (seed_load) begin
            lfsr_ff <= seed_value;
         end
         if (step.trig && note_on) begin
            active_ff <= 1'b1;
            len_ff    <= clip_len;
            pos_ff    <= '0;
            gain_ff   <= GAIN_ONE;
            fwd_ff    <= 1'b1;
            rep_ff    <= '0;
            if (cfg.mode == MODE_RANDOM) begin
               lfsr_ff   <= lfsr_in;
               rstart_ff <= lfsr_in[31:16];
            end
         end
         if (step.offs) begin
            replay_ff <= active_ff && (len_ff != '0);
         end
         if (step.mix) begin
            if (replay_ff) begin
               if (pos_sum >= len_q) begin
                  pos_ff  <= '0;
                  gain_ff <= gain_next;
                  if (rep_ff != 16'hFFFF) begin
                     rep_ff <= rep_ff + 16'd1;
                  end
                  if (cfg.mode == MODE_PINGPONG) begin
                     fwd_ff <= !fwd_ff;
                  end else if (cfg.mode == MODE_RANDOM) begin
                     lfsr_ff   <= lfsr_in;
                     rstart_ff <= lfsr_in[31:16];
                  end
                  if (gain_next < GAIN_STOP) begin
                     active_ff <= 1'b0;
                  end
               end else begin
                  pos_ff <= pos_sum;
               end
            end else begin
               wp_ff <= wp_ff + AW'(1);
               if (wp_ff == {AW{1'b1}}) begin
                  wrapped_ff <= 1'b1;
               end
            end
            // release acts after this frame
            if (note_off) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step.offs) begin
         off_ff <= OW'(rstart_ff) * OW'(LW'(BUFFER_DEPTH) - len_ff);
      end
      if (step.pos) begin
         addr0_ff <= i0;
         addr1_ff <= i1;
         frac_ff  <= p_sel[FB-1:0];
         // entries not yet written since reset read as zero
         v0_ff    <= wrapped_ff || (i0 < wp_ff);
         v1_ff    <= wrapped_ff || (i1 < wp_ff);
      end
   end

   assign addr0   = addr0_ff;
   assign addr1   = addr1_ff;
   assign wr_addr = wp_ff;
   assign frac    = frac_ff;
   assign valid0  = v0_ff;
   assign valid1  = v1_ff;
   assign replay  = replay_ff;
   assign gain    = gain_ff;
   assign repeats = rep_ff;

endmodule

[rtl/asr_lane.sv]
`timescale 1ns / 1ps
module asr_lane #(
   parameter int BUFFER_DEPTH  = 131072,
   parameter int SAMPLE_BITS   = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  asr_pkg::step_type                step,
   input  logic [$clog2(BUFFER_DEPTH)-1:0]  addr0,
   input  logic [$clog2(BUFFER_DEPTH)-1:0]  addr1,
   input  logic [$clog2(BUFFER_DEPTH)-1:0]  wr_addr,
   input  logic                             wr_en,
   input  logic                             valid0,
   input  logic                             valid1,
   input  logic [FRACTION_BITS-1:0]         frac,
   input  logic                             replay,
   input  logic [16:0]                      gain,
   input  logic [16:0]                      mix,
   input  logic signed [SAMPLE_BITS-1:0]    dry,
   output logic signed [SAMPLE_BITS-1:0]    mixed
);
   import asr_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int DW = SB + FB + 2;
   localparam int MW = SB + 18;

   logic signed [SB-1:0] mem [BUFFER_DEPTH];
   logic signed [SB-1:0] rd_ff, s0_ff, wet_ff;
   logic signed [DW-1:0] prod_ff;
   logic signed [MW-1:0] pd_ff, pw_ff;

   logic signed [SB-1:0] s1, interp;
   logic signed [SB:0]   diff;
   logic signed [DW-1:0] diff_x, frac_x, step_d;
   logic signed [MW-1:0] interp_x, gain_x, wet_prod;
   logic signed [MW:0]   sum, sum_sh;
   logic signed [MW:0]   max_v, min_v;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= dry;
      end
      if (step.rd0) begin
         rd_ff <= mem[addr0];
      end else if (step.rd1) begin
         rd_ff <= mem[addr1];
      end
   end

   always_comb begin
      s1       = valid1 ? rd_ff : '0;
      diff     = (SB+1)'(s1) - (SB+1)'(s0_ff);
      diff_x   = DW'(diff);
      frac_x   = $signed(DW'(frac));
      step_d   = prod_ff >>> FB;
      interp   = s0_ff + SB'(step_d);
      interp_x = MW'(interp);
      gain_x   = $signed(MW'(gain));
      wet_prod = (interp_x * gain_x) >>> 16;
      sum      = (MW+1)'(pd_ff) + (MW+1)'(pw_ff);
      sum_sh   = sum >>> 16;
      max_v    = $signed((MW+1)'({1'b0, {(SB-1){1'b1}}}));
      min_v    = -max_v - (MW+1)'(1);
      if (sum_sh > max_v) begin
         mixed = max_v[SB-1:0];
      end else if (sum_sh < min_v) begin
         mixed = min_v[SB-1:0];
      end else begin
         mixed = sum_sh[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (step.rd1) begin
         s0_ff <= valid0 ? rd_ff : '0;
      end
      if (step.intp) begin
         prod_ff <= diff_x * frac_x;
      end
      if (step.gain) begin
         wet_ff <= replay ? wet_prod[SB-1:0] : '0;
      end
      if (step.mix) begin
         pd_ff <= MW'(dry) * $signed(MW'(GAIN_ONE - mix));
         pw_ff <= MW'(wet_ff) * $signed(MW'(mix));
      end
   end

endmodule
